>>> hdl/aob_pkg.sv
`default_nettype none

package aob_pkg;

    localparam int CHAN_W    = 8;
    localparam int NUM_CHAN  = 3;
    localparam int NUM_CELLS = CHAN_W;
    localparam int NUM_W     = 2 * CHAN_W;
    localparam int DSH_W     = CHAN_W + NUM_CELLS - 1;
    localparam int PIX_W     = 32;

    localparam logic [CHAN_W-1:0] FULL_ALPHA = 8'hFF;

    typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] rgb_t;

    typedef struct packed {
        logic [NUM_CHAN-1:0][NUM_W-1:0] rem;
        logic [DSH_W-1:0]               dsh;
        rgb_t                           quo;
        logic [CHAN_W-1:0]              alpha;
    } div_t;

endpackage

`default_nettype wire

>>> hdl/aob_front.sv
`default_nettype none

module aob_front
    import aob_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             up_valid,
    output logic                  up_ready,
    input  wire logic [PIX_W-1:0] bottom_pixel,
    input  wire logic [PIX_W-1:0] top_pixel,
    output logic                  dn_valid,
    input  wire logic             dn_ready,
    output div_t                  dn_data
);

    logic              a_valid_reg;
    logic [CHAN_W-1:0] a_wa_reg;
    rgb_t              a_top_reg;
    rgb_t              a_bot_reg;
    logic [NUM_W-1:0]  a_prod_reg;
    logic              a_ready;

    logic              b_valid_reg;
    logic [CHAN_W-1:0] b_wa_reg;
    logic [CHAN_W-1:0] b_wb_reg;
    logic [CHAN_W-1:0] b_sum_reg;
    rgb_t              b_top_reg;
    rgb_t              b_bot_reg;
    logic              b_ready;

    logic              c_valid_reg;
    div_t              c_data_reg;
    logic              c_ready;

    logic [NUM_W:0]    wb_full;
    logic [CHAN_W-1:0] wb_next;
    logic [CHAN_W:0]   sum_full;
    div_t              c_data_next;

    assign a_ready  = !a_valid_reg || b_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign c_ready  = !c_valid_reg || dn_ready;
    assign up_ready = a_ready;
    assign dn_valid = c_valid_reg;
    assign dn_data  = c_data_reg;

    // Division by 255 of a 16-bit product, exact for every product of two 8-bit values.
    assign wb_full  = {1'b0, a_prod_reg} + (NUM_W+1)'(1)
                    + {{(CHAN_W+1){1'b0}}, a_prod_reg[NUM_W-1:CHAN_W]};
    assign wb_next  = wb_full[NUM_W-1:CHAN_W];
    assign sum_full = {1'b0, a_wa_reg} + {1'b0, wb_next};

    always_comb
    begin
        logic [NUM_W:0] num;
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            num = {1'b0, NUM_W'(b_bot_reg[c]) * NUM_W'(b_wb_reg)}
                + {1'b0, NUM_W'(b_top_reg[c]) * NUM_W'(b_wa_reg)};
            c_data_next.rem[c] = num[NUM_W-1:0];
        end
        c_data_next.dsh   = {b_sum_reg, {(NUM_CELLS-1){1'b0}}};
        c_data_next.quo   = '0;
        c_data_next.alpha = b_sum_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= up_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready)
            begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && up_valid)
        begin
            a_wa_reg   <= top_pixel[PIX_W-1:PIX_W-CHAN_W];
            a_top_reg  <= top_pixel[NUM_CHAN*CHAN_W-1:0];
            a_bot_reg  <= bottom_pixel[NUM_CHAN*CHAN_W-1:0];
            a_prod_reg <= NUM_W'(bottom_pixel[PIX_W-1:PIX_W-CHAN_W])
                        * NUM_W'(FULL_ALPHA - top_pixel[PIX_W-1:PIX_W-CHAN_W]);
        end
        if (b_ready && a_valid_reg)
        begin
            b_wa_reg  <= a_wa_reg;
            b_wb_reg  <= wb_next;
            b_sum_reg <= sum_full[CHAN_W-1:0];
            b_top_reg <= a_top_reg;
            b_bot_reg <= a_bot_reg;
        end
        if (c_ready && b_valid_reg)
        begin
            c_data_reg <= c_data_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/aob_div_cell.sv
`default_nettype none

module aob_div_cell
    import aob_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic up_valid,
    output logic      up_ready,
    input  wire div_t up_data,
    output logic      dn_valid,
    input  wire logic dn_ready,
    output div_t      dn_data
);

    logic valid_reg;
    div_t data_reg;
    div_t data_next;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    // One quotient bit per channel: compare against the shifted divisor and
    // hand the divisor on, shifted one place further down.
    always_comb
    begin
        logic ge;
        data_next = up_data;
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            ge = up_data.rem[c] >= {1'b0, up_data.dsh};
            data_next.rem[c] = ge ? up_data.rem[c] - {1'b0, up_data.dsh} : up_data.rem[c];
            data_next.quo[c] = {up_data.quo[c][CHAN_W-2:0], ge};
        end
        data_next.dsh = up_data.dsh >> 1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    a_rem_bound : assert property (@(posedge clk) disable iff (!rst_n)
        (up_valid && up_data.dsh != '0) |->
            (up_data.rem[0] < {up_data.dsh, 1'b0}) && (up_data.rem[1] < {up_data.dsh, 1'b0})
            && (up_data.rem[2] < {up_data.dsh, 1'b0}))
        else $error("remainder out of range for this quotient bit");

    a_take : assert property (@(posedge clk) disable iff (!rst_n)
        (up_valid && up_ready) |=> valid_reg)
        else $error("item taken but not held");

    a_hold : assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !dn_ready) |=> (valid_reg && $stable(data_reg)))
        else $error("stalled item changed");

endmodule

`default_nettype wire

>>> hdl/argb_alpha_over_blend_unit.sv
`default_nettype none

// Channel  Handshake                 Payload
// pair     pair_valid / pair_stall   bottom_pixel, top_pixel
// blend    blend_valid / blend_stall blended_pixel
//
// One item per clock is accepted while pair_stall is low; its result is offered
// once the item has passed the front stages and the divider cells.
// Three front stages form the weights and numerators, then eight divider cells
// each resolve one quotient bit of all three colour channels.
// Every stage has its own ready, so bubbles close up and items keep entering
// while a result waits. Reset only clears the valid flags.

module argb_alpha_over_blend_unit
    import aob_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             pair_valid,
    output logic                  pair_stall,
    input  wire logic [PIX_W-1:0] bottom_pixel,
    input  wire logic [PIX_W-1:0] top_pixel,
    output logic                  blend_valid,
    input  wire logic             blend_stall,
    output logic [PIX_W-1:0]      blended_pixel
);

    logic                 pair_ready;
    logic [NUM_CELLS:0]   cv;
    logic [NUM_CELLS:0]   cr;
    div_t [NUM_CELLS:0]   cd;
    div_t                 last;

    assign pair_stall = !pair_ready;

    aob_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .up_valid     (pair_valid),
        .up_ready     (pair_ready),
        .bottom_pixel (bottom_pixel),
        .top_pixel    (top_pixel),
        .dn_valid     (cv[0]),
        .dn_ready     (cr[0]),
        .dn_data      (cd[0])
    );

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        aob_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (cv[i]),
            .up_ready (cr[i]),
            .up_data  (cd[i]),
            .dn_valid (cv[i+1]),
            .dn_ready (cr[i+1]),
            .dn_data  (cd[i+1])
        );
    end

    assign last             = cd[NUM_CELLS];
    assign cr[NUM_CELLS]    = !blend_stall;
    assign blend_valid      = cv[NUM_CELLS];
    assign blended_pixel    = (last.alpha == '0) ? '0 : {last.alpha, last.quo};

endmodule

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import aob_pkg::*;

    localparam int RANDOM_ITEMS = 900;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 150;
    localparam int DRAIN_CYCLES = 30;
    localparam int IDLE_PERCENT = 37;

    typedef struct packed {
        logic [PIX_W-1:0] bottom;
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] want;
        logic             typed;
    } stim_row_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        int unsigned      item_no;
    } blend_expect_t;

    localparam int DIRECTED_ROWS = 19;

    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1},
        '{32'h00FF_FFFF, 32'h00FF_FFFF, 32'h0000_0000, 1'b1},
        '{32'h00A5_5AC3, 32'h003C_C381, 32'h0000_0000, 1'b1},
        '{32'h1234_5678, 32'hFF00_0000, 32'hFF00_0000, 1'b1},
        '{32'h0000_0000, 32'hFFAB_CDEF, 32'hFFAB_CDEF, 1'b1},
        '{32'hFFFF_FFFF, 32'hFF00_0000, 32'hFF00_0000, 1'b1},
        '{32'hFF10_2030, 32'h00FF_FFFF, 32'hFF10_2030, 1'b1},
        '{32'h7F80_8080, 32'h0000_0000, 32'h7F80_8080, 1'b1},
        '{32'h0100_0001, 32'h00FF_FF00, 32'h0100_0001, 1'b1},
        '{32'hFFFF_FFFF, 32'h8000_0000, 32'h0,         1'b0},
        '{32'h80FF_0000, 32'h8000_FF00, 32'h0,         1'b0},
        '{32'h01FF_FFFF, 32'h0100_0000, 32'h0,         1'b0},
        '{32'hFEFF_FFFF, 32'h0100_0000, 32'h0,         1'b0},
        '{32'hAAAA_AAAA, 32'h5555_5555, 32'h0,         1'b0},
        '{32'h5555_5555, 32'hAAAA_AAAA, 32'h0,         1'b0},
        '{32'hFF00_0000, 32'h7FFF_FFFF, 32'h0,         1'b0},
        '{32'hFFFF_FFFF, 32'hFE00_0000, 32'h0,         1'b0},
        '{32'h01FF_FFFF, 32'hFE00_0000, 32'h0,         1'b0}
    };

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             pair_valid = 1'b0;
    logic             pair_stall;
    logic [PIX_W-1:0] bottom_pixel = '0;
    logic [PIX_W-1:0] top_pixel = '0;
    logic             blend_valid;
    logic             blend_stall = 1'b0;
    logic [PIX_W-1:0] blended_pixel;

    blend_expect_t pending_blends [$];
    int unsigned   mismatch_count = 0;
    int unsigned   cycle_count = 0;
    int unsigned   items_sent = 0;
    bit            steady = 1'b0;
    bit            hold_request = 1'b0;

    argb_alpha_over_blend_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pair_valid   (pair_valid),
        .pair_stall   (pair_stall),
        .bottom_pixel (bottom_pixel),
        .top_pixel    (top_pixel),
        .blend_valid  (blend_valid),
        .blend_stall  (blend_stall),
        .blended_pixel(blended_pixel)
    );

    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("argb_alpha_over_blend_unit test failed");
            $finish;
        end
    end

    // Non-premultiplied over: the bottom alpha is scaled by what the top leaves.
    function automatic logic [PIX_W-1:0] blend_over(logic [PIX_W-1:0] bottom,
                                                    logic [PIX_W-1:0] top);
        int unsigned      top_weight;
        int unsigned      bottom_weight;
        int unsigned      alpha_sum;
        int unsigned      channel;
        logic [PIX_W-1:0] result;
        top_weight = top[31:24];
        bottom_weight = (bottom[31:24] * (int'(FULL_ALPHA) - top_weight)) / FULL_ALPHA;
        alpha_sum = top_weight + bottom_weight;
        result = '0;
        result[31:24] = alpha_sum[7:0];
        if (alpha_sum != 0)
        begin
            for (int k = 0; k < NUM_CHAN; k++)
            begin
                channel = (bottom[8*k +: 8] * bottom_weight + top[8*k +: 8] * top_weight)
                          / alpha_sum;
                result[8*k +: 8] = channel[7:0];
            end
        end
        return result;
    endfunction

    function automatic logic [CHAN_W-1:0] pick_alpha();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h01;
            3: return 8'hFE;
            default: return CHAN_W'($urandom_range(255));
        endcase
    endfunction

    task automatic report_mismatch(string what, int unsigned item_no,
                                   logic [PIX_W-1:0] got, logic [PIX_W-1:0] want);
        $display("%s: item %0d got %08h want %08h", what, item_no, got, want);
        mismatch_count++;
    endtask

    task automatic send_pair(logic [PIX_W-1:0] bottom, logic [PIX_W-1:0] top,
                             logic [PIX_W-1:0] want);
        while (!steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            pair_valid <= 1'b0;
            @(posedge clk);
        end
        pair_valid <= 1'b1;
        bottom_pixel <= bottom;
        top_pixel <= top;
        do
            @(posedge clk);
        while (pair_stall);
        pending_blends.push_back('{pixel: want, item_no: items_sent});
        items_sent++;
    endtask

    task automatic wait_for_drain();
        pair_valid <= 1'b0;
        @(posedge clk);
        while (pending_blends.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            int unsigned   hold_left;
            blend_expect_t oldest;
            @(posedge clk);
            if (blend_valid && !blend_stall)
            begin
                if (pending_blends.size() == 0)
                    report_mismatch("unexpected item", 0, blended_pixel, '0);
                else
                begin
                    oldest = pending_blends.pop_front();
                    if (blended_pixel !== oldest.pixel)
                        report_mismatch("blended_pixel", oldest.item_no, blended_pixel,
                                        oldest.pixel);
                end
            end
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                blend_stall <= 1'b1;
            end
            else if (steady)
                blend_stall <= 1'b0;
            else
                blend_stall <= ($urandom_range(99) < IDLE_PERCENT);
        end
    end

    initial
    begin
        logic [PIX_W-1:0] bottom;
        logic [PIX_W-1:0] top;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            send_pair(directed_rows[i].bottom, directed_rows[i].top,
                      directed_rows[i].typed ? directed_rows[i].want
                                             : blend_over(directed_rows[i].bottom,
                                                          directed_rows[i].top));
        end
        wait_for_drain();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            steady = (n >= 200 && n < 350);
            if (n == 450)
                hold_request = 1'b1;
            if (n == 650)
                wait_for_drain();
            bottom = {pick_alpha(), 24'($urandom)};
            top = {pick_alpha(), 24'($urandom)};
            send_pair(bottom, top, blend_over(bottom, top));
        end
        steady = 1'b0;
        pair_valid <= 1'b0;

        while (pending_blends.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("argb_alpha_over_blend_unit test passed");
        else
            $display("argb_alpha_over_blend_unit test failed");
        $finish;
    end

endmodule
